/* hw/rtl/tile_background_pixel_fetch_defines.svh */
// Assertion macros for the tile background pixel fetch block.
// Included by files that check their own pipeline; no other dependencies.
`ifndef TILE_BACKGROUND_PIXEL_FETCH_DEFINES_SVH
`define TILE_BACKGROUND_PIXEL_FETCH_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TBPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbpf check failed");
// Next-cycle implication.
`define TBPF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbpf check failed");
`else
`define TBPF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TBPF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/tbpf_pkg.sv */
// Shared constants, types and the shade lookup for the tile background fetch.
// No dependencies.
package tbpf_pkg;

    localparam int LINE_WIDTH  = 160;
    localparam int VRAM_BYTES  = 8192;
    localparam int ADDR_W      = 13;
    localparam int BANK_DEPTH  = VRAM_BYTES / 2;
    localparam int BANK_AW     = ADDR_W - 1;

    // Tile map sits at offset 0x1800 in video memory
    localparam logic [ADDR_W-1:0] MAP_BASE = 13'h1800;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    localparam logic REG_SCROLL_X = 1'b0;
    localparam logic REG_SCROLL_Y = 1'b1;

    localparam logic [1:0] CI_WHITE = 2'd0;
    localparam logic [1:0] CI_LIGHT = 2'd1;
    localparam logic [1:0] CI_DARK  = 2'd2;
    localparam logic [1:0] CI_BLACK = 2'd3;

    typedef struct packed {
        logic [7:0] column;
        logic [7:0] line;
        logic [2:0] fine_x;
        logic [2:0] fine_y;
        logic       map_odd;
    } t_pix_meta;

    function automatic logic [7:0] gray_of(input logic [1:0] ci);
        logic [7:0] g;
        unique case (ci)
            CI_WHITE: g = 8'hFF;
            CI_LIGHT: g = 8'hCC;
            CI_DARK:  g = 8'h77;
            CI_BLACK: g = 8'h00;
            default:  g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

/* hw/rtl/tile_background_pixel_fetch.sv */
// Tile background pixel fetch: an accepted render item passes stages 0, 1 and 2 to
// its result item; one item per cycle sustained, the pipeline stalls as a whole
// only while the output register waits on m_axis_tready.
// A write item lands in video memory at its accept edge and gives no result.
// Reset clears scroll registers and stage valid bits; video memory is left
// undefined and gets no clearing pass. Uses tbpf_pkg, tbpf_ram, tbpf_shade.
`include "tile_background_pixel_fetch_defines.svh"
module tile_background_pixel_fetch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [12:0] mem_address, [20:13] mem_data, [28:21] pixel_column,
    // [36:29] screen_line, [39:37] zero
    input  logic [39:0] s_axis_tdata,
    // [0] command
    input  logic        s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_column, [15:8] out_line, [17:16] color_index,
    // [25:18] gray_level, [31:26] zero
    output logic [31:0] m_axis_tdata
);

    localparam int AW  = tbpf_pkg::ADDR_W;
    localparam int BAW = tbpf_pkg::BANK_AW;

    logic [7:0] r_scroll_x;
    logic [7:0] r_scroll_y;

    logic        en;
    logic        accept;
    logic        is_write;
    logic [AW-1:0] wr_addr;
    logic [7:0]  wr_data;
    logic [7:0]  in_column;
    logic [7:0]  in_line;
    logic [7:0]  bg_x;
    logic [7:0]  bg_y;
    logic [AW-1:0] map_addr;
    logic        in_range;

    logic        r_v1;
    logic        r_v2;
    tbpf_pkg::t_pix_meta r_m1;
    tbpf_pkg::t_pix_meta r_m2;
    tbpf_pkg::t_pix_meta n_m1;

    logic [7:0]  even_map;
    logic [7:0]  odd_map;
    logic [7:0]  even_plane;
    logic [7:0]  odd_plane;
    logic [7:0]  tile;
    logic [BAW-1:0] plane_word;

    logic        out_valid;
    logic [7:0]  out_column;
    logic [7:0]  out_line;
    logic [1:0]  out_ci;
    logic [7:0]  out_gray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x <= 8'd0;
            r_scroll_y <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tbpf_pkg::REG_SCROLL_X: r_scroll_x <= i_cfg_wdata;
                tbpf_pkg::REG_SCROLL_Y: r_scroll_y <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together unless the result is blocked
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    assign wr_addr   = s_axis_tdata[12:0];
    assign wr_data   = s_axis_tdata[20:13];
    assign in_column = s_axis_tdata[28:21];
    assign in_line   = s_axis_tdata[36:29];
    assign is_write  = accept && (s_axis_tuser == tbpf_pkg::CMD_WRITE);

    // Stage 0: scroll, wrap, and issue the tile map read
    assign bg_x     = in_column + r_scroll_x;
    assign bg_y     = in_line + r_scroll_y;
    assign map_addr = tbpf_pkg::MAP_BASE | {3'b000, bg_y[7:3], bg_x[7:3]};
    assign in_range = {1'b0, in_column} < 9'(tbpf_pkg::LINE_WIDTH);

    always_comb begin
        n_m1.column  = in_column;
        n_m1.line    = in_line;
        n_m1.fine_x  = bg_x[2:0];
        n_m1.fine_y  = bg_y[2:0];
        n_m1.map_odd = map_addr[0];
    end

    // Stage 1: tile number known, issue both plane reads (even and odd byte)
    assign tile       = r_m1.map_odd ? odd_map : even_map;
    assign plane_word = {tile, r_m1.fine_y[2:0], 1'b0} >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= accept && (s_axis_tuser == tbpf_pkg::CMD_RENDER) && in_range;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1 <= n_m1;
            r_m2 <= r_m1;
        end
    end

    // Even bytes in one bank, odd bytes in the other: a plane pair is one row of both
    tbpf_ram #(
        .DEPTH (tbpf_pkg::BANK_DEPTH),
        .WIDTH (8)
    ) u_bank_even (
        .i_clk     (i_clk),
        .i_we      (is_write && !wr_addr[0]),
        .i_waddr   (wr_addr[AW-1:1]),
        .i_wdata   (wr_data),
        .i_re      (en),
        .i_raddr_a (map_addr[AW-1:1]),
        .i_raddr_b (plane_word),
        .o_rdata_a (even_map),
        .o_rdata_b (even_plane)
    );

    tbpf_ram #(
        .DEPTH (tbpf_pkg::BANK_DEPTH),
        .WIDTH (8)
    ) u_bank_odd (
        .i_clk     (i_clk),
        .i_we      (is_write && wr_addr[0]),
        .i_waddr   (wr_addr[AW-1:1]),
        .i_wdata   (wr_data),
        .i_re      (en),
        .i_raddr_a (map_addr[AW-1:1]),
        .i_raddr_b (plane_word),
        .o_rdata_a (odd_map),
        .o_rdata_b (odd_plane)
    );

    // Stage 2: bit select, shade, output register
    tbpf_shade u_shade (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (r_v2),
        .i_meta        (r_m2),
        .i_plane_one   (even_plane),
        .i_plane_two   (odd_plane),
        .o_valid       (out_valid),
        .o_column      (out_column),
        .o_line        (out_line),
        .o_color_index (out_ci),
        .o_gray_level  (out_gray)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {6'd0, out_gray, out_ci, out_line, out_column};

    `TBPF_ASSERT_IMP(a_ready_only_on_stall, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    `TBPF_ASSERT_NXT(a_write_no_item, i_clk, i_rst_n, is_write, !r_v1)
    `TBPF_ASSERT_NXT(a_stage_advance, i_clk, i_rst_n, r_v2 && en, m_axis_tvalid)
    `TBPF_ASSERT_IMP(a_shade_match, i_clk, i_rst_n, m_axis_tvalid, out_gray == tbpf_pkg::gray_of(out_ci))

endmodule

/* hw/rtl/tbpf_ram.sv */
// Generic memory: one write port, two registered read ports sharing a read enable.
// No dependencies.
module tbpf_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hw/rtl/tbpf_shade.sv */
// Last pipeline stage: picks the pixel bit from both planes, maps it to gray,
// and holds the result item in the output register. Uses tbpf_pkg.
module tbpf_shade (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  tbpf_pkg::t_pix_meta i_meta,
    input  logic [7:0]          i_plane_one,
    input  logic [7:0]          i_plane_two,
    output logic                o_valid,
    output logic [7:0]          o_column,
    output logic [7:0]          o_line,
    output logic [1:0]          o_color_index,
    output logic [7:0]          o_gray_level
);

    logic       r_valid;
    logic [7:0] r_column;
    logic [7:0] r_line;
    logic [1:0] r_ci;
    logic [7:0] r_gray;
    logic [2:0] bit_sel;
    logic [1:0] n_ci;

    // Leftmost pixel is bit 7
    assign bit_sel = 3'd7 - i_meta.fine_x;
    assign n_ci    = {i_plane_two[bit_sel], i_plane_one[bit_sel]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_column <= i_meta.column;
            r_line   <= i_meta.line;
            r_ci     <= n_ci;
            r_gray   <= tbpf_pkg::gray_of(n_ci);
        end
    end

    assign o_valid       = r_valid;
    assign o_column      = r_column;
    assign o_line        = r_line;
    assign o_color_index = r_ci;
    assign o_gray_level  = r_gray;

endmodule

/* verif/tile_background_pixel_fetch_tb.sv */
// Self-checking testbench for tile_background_pixel_fetch: random and directed items
// go through the stream ports, and a scoreboard class predicts every rendered pixel.
// Depends on tbpf_pkg and the tile_background_pixel_fetch RTL.
module tile_background_pixel_fetch_tb;

    localparam int AW            = tbpf_pkg::ADDR_W;
    localparam int VRAM_BYTES    = tbpf_pkg::VRAM_BYTES;
    localparam int LINE_WIDTH    = tbpf_pkg::LINE_WIDTH;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;

    // lowest field first: column, line, color index, gray level
    typedef struct packed {
        logic [7:0] gray;
        logic [1:0] ci;
        logic [7:0] line;
        logic [7:0] column;
    } t_px_result;

    class t_pixel_scoreboard;
        logic [7:0]   vram_copy [VRAM_BYTES];
        bit           written [VRAM_BYTES];
        logic [7:0]   scroll_x;
        logic [7:0]   scroll_y;
        t_px_result   pixel_q [$];
        int           mismatches;

        function new();
            scroll_x   = 8'd0;
            scroll_y   = 8'd0;
            mismatches = 0;
        endfunction

        function void set_reg(input logic idx, input logic [7:0] value);
            if (idx == tbpf_pkg::REG_SCROLL_X)
                scroll_x = value;
            else
                scroll_y = value;
        endfunction

        function logic [AW-1:0] map_addr_of(input logic [7:0] col,
                                            input logic [7:0] line);
            logic [7:0] bx;
            logic [7:0] by;
            bx = col + scroll_x;
            by = line + scroll_y;
            return tbpf_pkg::MAP_BASE + {3'b000, by[7:3], bx[7:3]};
        endfunction

        function logic [AW-1:0] row_addr_of(input logic [7:0] tile,
                                            input logic [7:0] line);
            logic [7:0] by;
            by = line + scroll_y;
            return {1'b0, tile, by[2:0], 1'b0};
        endfunction

        function void note_item(input logic cmd, input logic [AW-1:0] addr,
                                input logic [7:0] data, input logic [7:0] col,
                                input logic [7:0] line);
            logic [AW-1:0]     row;
            logic [7:0]        bx;
            logic [7:0]        p1;
            logic [7:0]        p2;
            logic [2:0]        pos;
            t_px_result        px;
            if (cmd == tbpf_pkg::CMD_WRITE) begin
                vram_copy[addr] = data;
                written[addr]   = 1'b1;
                return;
            end
            if (col >= LINE_WIDTH)
                return;
            bx  = col + scroll_x;
            row = row_addr_of(vram_copy[map_addr_of(col, line)], line);
            p1  = vram_copy[row];
            p2  = vram_copy[row | 1];
            pos = 3'd7 - bx[2:0];
            px.column = col;
            px.line   = line;
            px.ci     = {p2[pos], p1[pos]};
            case (px.ci)
                tbpf_pkg::CI_WHITE: px.gray = 8'hFF;
                tbpf_pkg::CI_LIGHT: px.gray = 8'hCC;
                tbpf_pkg::CI_DARK:  px.gray = 8'h77;
                default:            px.gray = 8'h00;
            endcase
            pixel_q.push_back(px);
        endfunction

        function void check_result(input logic [31:0] tdata);
            t_px_result got;
            t_px_result want;
            got = tdata[25:0];
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel item: col %0d line %0d ci %0d gray %02h",
                             got.column, got.line, got.ci, got.gray);
                return;
            end
            want = pixel_q.pop_front();
            if (got.column !== want.column || got.line !== want.line ||
                got.ci !== want.ci || got.gray !== want.gray) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"pixel mismatch: exp col %0d line %0d ci %0d gray %02h,",
                              " got col %0d line %0d ci %0d gray %02h"},
                             want.column, want.line, want.ci, want.gray,
                             got.column, got.line, got.ci, got.gray);
            end
        endfunction

        function int outstanding();
            return pixel_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = 40'd0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    t_pixel_scoreboard sb = new();
    bit steady = 1'b0;
    int items_done = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    tile_background_pixel_fetch u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Pixel receiver: check accepted items, stall at random, serve long hold-offs
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holds_served < hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && (steady || $urandom_range(99) >= 10);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("** tile_background_pixel_fetch: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [AW-1:0] addr,
                             input logic [7:0] data, input logic [7:0] col,
                             input logic [7:0] line);
        if (!steady && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, line, col, data, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(cmd, addr, data, col, line);
    endtask

    // pixel fields of a write are don't-care: fill them with noise
    task automatic send_write(input logic [AW-1:0] addr, input logic [7:0] data);
        send_item(tbpf_pkg::CMD_WRITE, addr, data, 8'($urandom_range(255)),
                  8'($urandom_range(255)));
        items_done++;
    endtask

    task automatic send_render(input logic [7:0] col, input logic [7:0] line);
        send_item(tbpf_pkg::CMD_RENDER, AW'($urandom_range(VRAM_BYTES - 1)),
                  8'($urandom_range(255)), col, line);
        if (col < LINE_WIDTH)
            items_done++;
    endtask

    // Fill in whatever map entry and tile row bytes the pixel reads before rendering it
    task automatic render_with_setup(input logic [7:0] col, input logic [7:0] line);
        logic [AW-1:0] ma;
        logic [AW-1:0] ra;
        ma = sb.map_addr_of(col, line);
        if (!sb.written[ma])
            send_write(ma, 8'($urandom_range(255)));
        ra = sb.row_addr_of(sb.vram_copy[ma], line);
        if (!sb.written[ra])
            send_write(ra, 8'($urandom_range(255)));
        if (!sb.written[ra | 1])
            send_write(ra | 1, 8'($urandom_range(255)));
        send_render(col, line);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scroll(input logic [7:0] x, input logic [7:0] y);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tbpf_pkg::REG_SCROLL_X;
        i_cfg_wdata <= x;
        @(posedge i_clk);
        sb.set_reg(tbpf_pkg::REG_SCROLL_X, x);
        i_cfg_index <= tbpf_pkg::REG_SCROLL_Y;
        i_cfg_wdata <= y;
        @(posedge i_clk);
        sb.set_reg(tbpf_pkg::REG_SCROLL_Y, y);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int target, input bit with_hold);
        int start;
        int pick;
        int run_len;
        bit hold_sent;
        logic [7:0] col;
        logic [7:0] line;
        start = items_done;
        hold_sent = 1'b0;
        while (items_done - start < target) begin
            // request the hold-off once, a quarter of the way in
            if (with_hold && !hold_sent && items_done - start >= target / 4) begin
                hold_requests++;
                hold_sent = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 18) begin
                send_write(AW'($urandom_range(VRAM_BYTES - 1)), 8'($urandom_range(255)));
            end else if (pick < 24) begin
                // retile a map entry
                send_write(tbpf_pkg::MAP_BASE + AW'($urandom_range(1023)),
                           8'($urandom_range(255)));
            end else if (pick < 29) begin
                send_render(8'($urandom_range(LINE_WIDTH, 255)), 8'($urandom_range(255)));
            end else if (pick < 45) begin
                // short burst along one line, may run past the right edge
                col  = 8'($urandom_range(LINE_WIDTH - 1));
                line = 8'($urandom_range(255));
                run_len = $urandom_range(4, 16);
                repeat (run_len) begin
                    render_with_setup(col, line);
                    col = col + 8'd1;
                end
            end else begin
                render_with_setup(8'($urandom_range(LINE_WIDTH - 1)),
                                  8'($urandom_range(255)));
            end
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_scroll(8'd0, 8'd0);

        // tile 255 row 0 holds all four color indices in its first four pixels
        send_write(tbpf_pkg::MAP_BASE, 8'hFF);
        send_write(13'h0FF0, 8'h55);
        send_write(13'h0FF1, 8'h33);
        for (int c = 0; c < 4; c++)
            send_render(8'(c), 8'd0);
        send_render(8'(LINE_WIDTH), 8'd0);
        send_render(8'd255, 8'd0);
        send_write(13'h1FFF, 8'h00);
        send_write(13'h0000, 8'h00);
        render_with_setup(8'(LINE_WIDTH - 1), 8'd255);
        render_with_setup(8'(LINE_WIDTH - 1), 8'd143);
        drain();

        // both sums wrap back onto tile 255 at the origin
        write_scroll(8'd255, 8'd255);
        send_render(8'd1, 8'd1);
        send_render(8'd4, 8'd1);
        render_with_setup(8'(LINE_WIDTH - 1), 8'd255);
        render_with_setup(8'd0, 8'd0);
        drain();

        write_scroll(8'($urandom_range(255)), 8'($urandom_range(255)));
        run_random(410, 1'b0);
        write_scroll(8'd0, 8'd255);
        run_random(410, 1'b1);
        write_scroll(8'd255, 8'd0);
        steady = 1'b1;
        run_random(250, 1'b0);
        steady = 1'b0;
        run_random(160, 1'b0);
        write_scroll(8'($urandom_range(255)), 8'($urandom_range(255)));
        run_random(410, 1'b0);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("** tile_background_pixel_fetch: PASSED **");
        else
            $display("** tile_background_pixel_fetch: FAILED **");
        $finish;
    end

endmodule
